FILE: sv/ptdnat_pkg.sv
package ptdnat_pkg;

  localparam int InTdataW  = 104;
  localparam int OutTdataW = 40;
  localparam int RuleW     = 16;
  localparam int AddrW     = 32;
  localparam int PortW     = 16;
  localparam int SecW      = 16;

  typedef enum logic [1:0] {
    HOOK_FORWARD    = 2'd0,
    HOOK_PREROUTING = 2'd1,
    HOOK_OTHER      = 2'd2,
    HOOK_RESERVED   = 2'd3
  } hook_t;

  typedef enum logic [1:0] {
    PROTO_OTHER    = 2'd0,
    PROTO_TCP      = 2'd1,
    PROTO_UDP      = 2'd2,
    PROTO_RESERVED = 2'd3
  } proto_t;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_ACCEPT   = 2'd1,
    VERDICT_REDIRECT = 2'd2,
    VERDICT_UNUSED   = 2'd3
  } verdict_t;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic             is_tick;
    hook_t            hook_point;
    logic             conn_is_new;
    logic [RuleW-1:0] rule_id;
    logic [SecW-1:0]  rule_timeout_seconds;
    logic             rule_match_port;
    proto_t           protocol_kind;
    logic [AddrW-1:0] source_address;
    logic [PortW-1:0] source_port;
    logic [PortW-1:0] dest_port;
  } pkt_item_t;

  // Port seen by the trigger: only TCP and UDP carry one.
  function automatic logic [PortW-1:0] transport_port(proto_t proto, logic [PortW-1:0] port);
    logic [PortW-1:0] res;
    res = '0;
    if (proto == PROTO_TCP || proto == PROTO_UDP) begin
      res = port;
    end
    return res;
  endfunction

endpackage

FILE: sv/port_trigger_dnat_policy.sv
// Channel  | Dir | Ports                      | Item
// ---------+-----+----------------------------+------------------------------------
// in_      | in  | tvalid tready tdata tuser  | packet summary or one-second tick
// out_     | out | tvalid tready tdata        | verdict and redirect address
//
// One item per cycle while out_tready does not hold the result register; a packet
// passes the input register, then decision and state update into the result register.
// Ticks produce no result item and never wait on the output side.
// Reset (rst_n low, synchronous) drops the trigger entry and empties both stages.
// A packet waits in the input register while the result register is held by out_tready.
module port_trigger_dnat_policy (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // hook_point[1:0], conn_is_new[2], rule_id[18:3], rule_timeout_seconds[34:19],
  // rule_match_port[35], protocol_kind[37:36], source_address[69:38],
  // source_port[85:70], dest_port[101:86], zero [103:102]
  input  logic [ptdnat_pkg::InTdataW-1:0]    in_tdata,
  // command[0]: 0 packet, 1 tick
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // verdict[1:0], redirect_address[33:2], zero [39:34]
  output logic [ptdnat_pkg::OutTdataW-1:0]   out_tdata
);
  import ptdnat_pkg::*;

  pkt_item_t        s1_item_r;
  logic             s1_vld_r, s1_vld_nxt;
  pkt_item_t        in_item;
  logic             s1_adv;

  logic             entry_valid_r, entry_valid_nxt;
  logic [RuleW-1:0] owner_rule_r, owner_rule_nxt;
  logic [AddrW-1:0] saved_address_r, saved_address_nxt;
  logic [PortW-1:0] saved_port_r, saved_port_nxt;
  logic [SecW-1:0]  seconds_left_r, seconds_left_nxt;

  logic             out_vld_r, out_vld_nxt;
  verdict_t         verdict_r, verdict_nxt;
  logic [AddrW-1:0] raddr_r, raddr_nxt;
  logic             res_load;
  logic             rule_hit;

  always_comb begin
    in_item.is_tick              = in_tuser;
    in_item.hook_point           = hook_t'(in_tdata[1:0]);
    in_item.conn_is_new          = in_tdata[2];
    in_item.rule_id              = in_tdata[18:3];
    in_item.rule_timeout_seconds = in_tdata[34:19];
    in_item.rule_match_port      = in_tdata[35];
    in_item.protocol_kind        = proto_t'(in_tdata[37:36]);
    in_item.source_address       = in_tdata[69:38];
    in_item.source_port          = in_tdata[85:70];
    in_item.dest_port            = in_tdata[101:86];
  end

  // ticks never need the result register
  assign s1_adv    = s1_vld_r && (s1_item_r.is_tick || !out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign res_load  = s1_adv && !s1_item_r.is_tick;
  assign rule_hit  = entry_valid_r && (owner_rule_r == s1_item_r.rule_id);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_tready) begin
      s1_vld_nxt = in_tvalid;
    end
  end

  always_comb begin
    entry_valid_nxt   = entry_valid_r;
    owner_rule_nxt    = owner_rule_r;
    saved_address_nxt = saved_address_r;
    saved_port_nxt    = saved_port_r;
    seconds_left_nxt  = seconds_left_r;
    verdict_nxt       = VERDICT_CONTINUE;
    raddr_nxt         = '0;
    if (s1_adv) begin
      if (s1_item_r.is_tick) begin
        if (entry_valid_r) begin
          if (seconds_left_r <= SecW'(1)) begin
            seconds_left_nxt = '0;
            entry_valid_nxt  = 1'b0;
          end else begin
            seconds_left_nxt = seconds_left_r - SecW'(1);
          end
        end
      end else begin
        case (s1_item_r.hook_point)
          HOOK_FORWARD: begin
            if (!entry_valid_r) begin
              entry_valid_nxt   = 1'b1;
              owner_rule_nxt    = s1_item_r.rule_id;
              saved_address_nxt = s1_item_r.source_address;
              saved_port_nxt    = transport_port(s1_item_r.protocol_kind,
                                                 s1_item_r.source_port);
              seconds_left_nxt  = s1_item_r.rule_timeout_seconds;
              verdict_nxt       = VERDICT_ACCEPT;
            end else if (rule_hit) begin
              verdict_nxt = VERDICT_ACCEPT;
            end
          end
          HOOK_PREROUTING: begin
            if (s1_item_r.conn_is_new && rule_hit &&
                (!s1_item_r.rule_match_port ||
                 transport_port(s1_item_r.protocol_kind, s1_item_r.dest_port)
                   == saved_port_r)) begin
              verdict_nxt = VERDICT_REDIRECT;
              raddr_nxt   = saved_address_r;
            end
          end
          default: begin
            verdict_nxt = VERDICT_CONTINUE;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      entry_valid_r   <= 1'b0;
      owner_rule_r    <= '0;
      saved_address_r <= '0;
      saved_port_r    <= '0;
      seconds_left_r  <= '0;
    end else begin
      s1_vld_r        <= s1_vld_nxt;
      out_vld_r       <= out_vld_nxt;
      entry_valid_r   <= entry_valid_nxt;
      owner_rule_r    <= owner_rule_nxt;
      saved_address_r <= saved_address_nxt;
      saved_port_r    <= saved_port_nxt;
      seconds_left_r  <= seconds_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
    if (res_load) begin
      verdict_r <= verdict_nxt;
      raddr_r   <= raddr_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutTdataW - AddrW - 2){1'b0}}, raddr_r, verdict_r};

  // an idle entry always has a cleared countdown
  a_idle_sec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !entry_valid_r |-> seconds_left_r == '0)
    else $error("countdown nonzero with no entry held");

  // entry is dropped only by a tick
  a_fall_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(entry_valid_r) |-> $past(s1_adv && s1_item_r.is_tick))
    else $error("entry cleared without a tick");

  // a fresh entry belongs to the forward packet that made it
  a_rise_owner: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(entry_valid_r) |-> owner_rule_r == $past(s1_item_r.rule_id))
    else $error("entry owner differs from registering packet");

  // address is carried only with a redirect
  a_addr_redirect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && verdict_r != VERDICT_REDIRECT) |-> raddr_r == '0)
    else $error("redirect address without redirect verdict");

  a_no_unused_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> verdict_r != VERDICT_UNUSED)
    else $error("undefined verdict code");

endmodule

FILE: tb/port_trigger_dnat_policy_tb.sv
module port_trigger_dnat_policy_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptdnat_pkg::*;

  typedef struct {
    logic             is_tick;
    hook_t            hook;
    logic             is_new;
    logic [RuleW-1:0] rule;
    logic [SecW-1:0]  secs;
    logic             match_port;
    proto_t           proto;
    logic [AddrW-1:0] saddr;
    logic [PortW-1:0] sport;
    logic [PortW-1:0] dport;
  } trig_item_t;

  typedef struct {
    verdict_t         verdict;
    logic [AddrW-1:0] addr;
  } verdict_rec_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata = '0;
  logic                 in_tuser = CMD_PACKET;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;

  // trigger entry as the testbench sees it
  logic             trig_valid = 1'b0;
  logic [RuleW-1:0] trig_rule = '0;
  logic [AddrW-1:0] trig_addr = '0;
  logic [PortW-1:0] trig_port = '0;
  logic [SecW-1:0]  trig_secs = '0;

  verdict_rec_t     pending_verdicts[$];
  // known values before the random phases fill it, so early ticks carry no X
  logic [RuleW-1:0] rule_pool[4] = '{default: '0};
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               error_count = 0;

  port_trigger_dnat_policy dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  function automatic logic [PortW-1:0] l4_port(proto_t proto, logic [PortW-1:0] port);
    return (proto == PROTO_TCP || proto == PROTO_UDP) ? port : '0;
  endfunction

  // Updates the entry for one accepted item and queues the verdict it yields.
  function automatic void decide_verdict(trig_item_t it);
    verdict_rec_t r;
    r.verdict = VERDICT_CONTINUE;
    r.addr = '0;
    if (it.is_tick) begin
      if (trig_valid) begin
        if (trig_secs <= 1) begin
          trig_secs = '0;
          trig_valid = 1'b0;
        end else begin
          trig_secs = trig_secs - 1'b1;
        end
      end
      return;
    end
    case (it.hook)
      HOOK_FORWARD: begin
        if (!trig_valid) begin
          trig_valid = 1'b1;
          trig_rule = it.rule;
          trig_addr = it.saddr;
          trig_port = l4_port(it.proto, it.sport);
          trig_secs = it.secs;
          r.verdict = VERDICT_ACCEPT;
        end else if (trig_rule == it.rule) begin
          r.verdict = VERDICT_ACCEPT;
        end
      end
      HOOK_PREROUTING: begin
        if (it.is_new && trig_valid && trig_rule == it.rule &&
            (!it.match_port || l4_port(it.proto, it.dport) == trig_port)) begin
          r.verdict = VERDICT_REDIRECT;
          r.addr = trig_addr;
        end
      end
      default: ;
    endcase
    pending_verdicts.push_back(r);
  endfunction

  function automatic logic [InTdataW-1:0] pack_item(trig_item_t it);
    return {2'b00, it.dport, it.sport, it.saddr, it.proto, it.match_port, it.secs,
            it.rule, it.is_new, it.hook};
  endfunction

  function automatic trig_item_t pkt(hook_t hook, logic is_new, logic [RuleW-1:0] rule,
                                     logic [SecW-1:0] secs, logic match_port, proto_t proto,
                                     logic [AddrW-1:0] saddr, logic [PortW-1:0] sport,
                                     logic [PortW-1:0] dport);
    trig_item_t it;
    it.is_tick = 1'b0;
    it.hook = hook;
    it.is_new = is_new;
    it.rule = rule;
    it.secs = secs;
    it.match_port = match_port;
    it.proto = proto;
    it.saddr = saddr;
    it.sport = sport;
    it.dport = dport;
    return it;
  endfunction

  function automatic trig_item_t random_item();
    trig_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.is_tick = ($urandom_range(99) < 20);
    it.hook = pick < 35 ? HOOK_FORWARD : pick < 80 ? HOOK_PREROUTING :
              pick < 92 ? HOOK_OTHER : HOOK_RESERVED;
    it.is_new = ($urandom_range(99) < 85);
    it.rule = ($urandom_range(99) < 80) ? rule_pool[$urandom_range(3)] : 16'($urandom);
    // short lifetimes when the item may register, so entries keep turning over
    it.secs = trig_valid ? 16'($urandom) : 16'($urandom_range(6));
    it.match_port = 1'($urandom_range(1));
    it.proto = proto_t'($urandom_range(3));
    it.saddr = $urandom;
    it.sport = 16'($urandom);
    it.dport = ($urandom_range(1) == 1) ? trig_port : 16'($urandom);
    return it;
  endfunction

  function automatic trig_item_t tick_item();
    trig_item_t it;
    it = random_item();
    it.is_tick = 1'b1;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(trig_item_t it);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.is_tick ? CMD_TICK : CMD_PACKET;
    in_tdata  <= pack_item(it);
    do @(posedge clk); while (!in_tready);
    decide_verdict(it);
  endtask

  task automatic test_register_and_hold();
    send_item(pkt(HOOK_FORWARD, 1'b1, 16'hFFFF, 16'd2, 1'b0, PROTO_TCP,
                  32'hFFFF_FFFF, 16'hFFFF, 16'h0000));
    send_item(pkt(HOOK_FORWARD, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, PROTO_UDP,
                  32'h0000_0000, 16'h0000, 16'hFFFF));
    send_item(pkt(HOOK_FORWARD, 1'b1, 16'h0000, 16'hFFFF, 1'b0, PROTO_TCP,
                  32'h1234_5678, 16'h0001, 16'h0001));
  endtask

  task automatic test_redirect();
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'hFFFF, 16'h0, 1'b0, PROTO_UDP,
                  32'hA5A5_5A5A, 16'h1111, 16'h2222));
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'hFFFF, 16'h0, 1'b1, PROTO_TCP,
                  32'h0, 16'h0, 16'hFFFF));
    // port required but different
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'hFFFF, 16'h0, 1'b1, PROTO_UDP,
                  32'h0, 16'h0, 16'hFFFE));
    send_item(pkt(HOOK_PREROUTING, 1'b0, 16'hFFFF, 16'h0, 1'b0, PROTO_TCP,
                  32'h0, 16'h0, 16'hFFFF));
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'h0001, 16'h0, 1'b0, PROTO_TCP,
                  32'h0, 16'h0, 16'hFFFF));
    // non-TCP/UDP packet compares port 0 against the stored 0xFFFF
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'hFFFF, 16'h0, 1'b1, PROTO_OTHER,
                  32'h0, 16'h0, 16'hFFFF));
    send_item(pkt(HOOK_OTHER, 1'b1, 16'hFFFF, 16'h5, 1'b0, PROTO_TCP,
                  32'h1, 16'h1, 16'h1));
    send_item(pkt(HOOK_RESERVED, 1'b1, 16'hFFFF, 16'h5, 1'b0, PROTO_TCP,
                  32'h1, 16'h1, 16'h1));
  endtask

  task automatic test_expiry();
    send_item(tick_item());
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'hFFFF, 16'h0, 1'b0, PROTO_TCP,
                  32'h0, 16'h0, 16'h0));
    send_item(tick_item());
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'hFFFF, 16'h0, 1'b0, PROTO_TCP,
                  32'h0, 16'h0, 16'h0));
    send_item(tick_item());
  endtask

  task automatic test_other_protocols();
    // zero lifetime, stored port forced to 0
    send_item(pkt(HOOK_FORWARD, 1'b1, 16'h0000, 16'h0, 1'b1, PROTO_OTHER,
                  32'h0, 16'hABCD, 16'h0));
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'h0000, 16'h0, 1'b1, PROTO_RESERVED,
                  32'hFFFF_FFFF, 16'hFFFF, 16'h1234));
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'h0000, 16'h0, 1'b1, PROTO_TCP,
                  32'h0, 16'h0, 16'h0));
    send_item(tick_item());
    send_item(pkt(HOOK_PREROUTING, 1'b1, 16'h0000, 16'h0, 1'b0, PROTO_TCP,
                  32'h0, 16'h0, 16'h0));
  endtask

  task automatic test_random_traffic(int count, int sender_idle, int receiver_stall);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    foreach (rule_pool[k]) rule_pool[k] = 16'($urandom);
    repeat (count) send_item(random_item());
  endtask

  // result checker; also drives the receiver's ready
  always @(posedge clk) begin
    verdict_rec_t want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("item with nothing expected", 32'h0, out_tdata[31:0]);
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_t'(out_tdata[1:0]) != want.verdict)
          report_mismatch("verdict", 32'(want.verdict), 32'(out_tdata[1:0]));
        if (out_tdata[33:2] != want.addr)
          report_mismatch("redirect_address", want.addr, out_tdata[33:2]);
      end
    end
  end

  initial begin
    int waited;
    waited = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_register_and_hold();
    test_redirect();
    test_expiry();
    test_other_protocols();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 80, 0);
    test_random_traffic(300, 0, 80);
    test_random_traffic(300, 29, 29);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch("items never delivered", 32'h0, 32'(pending_verdicts.size()));
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
